/* hdl/pts_pkg.sv */
// Shared types, codes and ranking function for the preemptive priority scheduler.
package pts_pkg;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_DRAIN   = 1'b1;
  localparam logic EV_DONE     = 1'b0;
  localparam logic EV_DROP     = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] task_id;
    logic [31:0] arrive_time;
    logic [31:0] work_amount;
    logic [15:0] priority_level;
  } req_t;

  typedef struct packed {
    logic [15:0] done_id;
    logic [47:0] finish_time;
    logic        event_kind;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arrival;
    logic [31:0] remaining;
    logic [15:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic ranks_above(entry_t a, entry_t b);
    if (a.prio != b.prio) begin
      return a.prio > b.prio;
    end
    return a.arrival < b.arrival;
  endfunction

endpackage

/* hdl/pts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/preemptive_priority_task_scheduler.sv */
// Top level: preemptive priority scheduler over a binary max-heap in one RAM.
//
// Usage: present a request on the request port with start high; it is taken
// at a clock edge where busy is low. A request is an arrival (id, arrival
// time, work, priority) or a drain. Each result (completed task or dropped
// arrival) appears on result for exactly one cycle with result_valid high;
// the last result caused by a request has last_of_run set. The receiver
// cannot stall; every strobed result is a transfer.
// Each completion costs a root read, a pop and a sift-down through the RAM;
// an insert costs a sift-up. Every request but a drain on an empty heap
// ends in a closing state. These costs are set by the single registered
// RAM read port; one request is worked on at a time, busy stays high until
// its final result has left. A drain on an empty heap and an arrival to an
// empty heap finish with no result or the insert only.
// Reset clears the heap count, the clock and the control state; the heap
// RAM is not cleared, as entries beyond the count are never read.
module preemptive_priority_task_scheduler #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pts_pkg::req_t request,
  output logic          result_valid,
  output pts_pkg::res_t result
);
  import pts_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int LW = AW + 2;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_RD_ROOT = 13'b0000000000010,
    S_CHK     = 13'b0000000000100,
    S_POP_RD  = 13'b0000000001000,
    S_POP_LD  = 13'b0000000010000,
    S_DN_CHK  = 13'b0000000100000,
    S_DN_RDR  = 13'b0000001000000,
    S_DN_CMPR = 13'b0000010000000,
    S_DN_CMP  = 13'b0000100000000,
    S_INS     = 13'b0001000000000,
    S_UP_CHK  = 13'b0010000000000,
    S_UP_CMP  = 13'b0100000000000,
    S_FIN     = 13'b1000000000000
  } state_t;

  state_t        state;
  req_t          req;
  logic [CW-1:0] count;
  logic [47:0]   ctime;
  logic [47:0]   eff;
  entry_t        elem;
  entry_t        cand;
  logic [AW-1:0] pos;
  logic [AW-1:0] cidx;
  logic          pend_v;
  res_t          pend;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t        rdata;

  logic [LW-1:0] lidx;
  logic [LW-1:0] ridx;
  logic [AW-1:0] up;
  logic [48:0]   fin_sum;
  logic          done_cond;
  logic [47:0]   arr_ext;
  logic          out_fire;
  logic          out_last;

  assign rdata     = entry_t'(rdata_raw);
  assign lidx      = LW'({pos, 1'b1});
  assign ridx      = lidx + LW'(1);
  assign up        = AW'((pos - AW'(1)) >> 1);
  assign fin_sum   = {1'b0, ctime} + 49'(rdata.remaining);
  assign done_cond = (req.req_type == REQ_DRAIN) || (fin_sum <= {1'b0, eff});
  assign arr_ext   = {16'd0, request.arrive_time};
  assign busy      = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = elem;
    re    = 1'b0;
    raddr = '0;
    unique case (state)
      S_RD_ROOT: begin
        re = 1'b1;
      end
      S_CHK: begin
        if (!done_cond) begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata;
          wdata.remaining = rdata.remaining - 32'(eff - ctime);
        end
      end
      S_POP_RD: begin
        re    = 1'b1;
        raddr = count[AW-1:0];
      end
      S_DN_CHK: begin
        if (lidx < LW'(count)) begin
          re    = 1'b1;
          raddr = lidx[AW-1:0];
        end else begin
          we = 1'b1;
        end
      end
      S_DN_RDR: begin
        if (ridx < LW'(count)) begin
          re    = 1'b1;
          raddr = ridx[AW-1:0];
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (ranks_above(cand, elem)) begin
          wdata = cand;
        end
      end
      S_UP_CHK: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = up;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (ranks_above(elem, rdata)) begin
          wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_fire = 1'b0;
    out_last = 1'b0;
    if (pend_v) begin
      if (state == S_CHK) begin
        out_fire = done_cond;
      end else if (state == S_INS) begin
        out_fire = (count == CW'(HEAP_DEPTH));
      end else if (state == S_FIN) begin
        out_fire = 1'b1;
        out_last = 1'b1;
      end
    end
  end

  pts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HEAP_DEPTH)
  ) u_heap (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= out_fire;
      if (out_fire) begin
        result <= {pend.done_id, pend.finish_time, pend.event_kind,
                   pend.last_of_run | out_last};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ctime  <= '0;
      pend_v <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= request;
            if (request.req_type == REQ_DRAIN) begin
              if (count != '0) begin
                state <= S_RD_ROOT;
              end
            end else if (count == '0) begin
              ctime <= arr_ext;
              state <= S_INS;
            end else begin
              eff   <= (arr_ext > ctime) ? arr_ext : ctime;
              state <= S_RD_ROOT;
            end
          end
        end
        S_RD_ROOT: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (done_cond) begin
            ctime <= (count == CW'(1) && req.req_type != REQ_DRAIN) ? eff : fin_sum[47:0];
            pend_v           <= 1'b1;
            pend.done_id     <= rdata.id;
            pend.finish_time <= fin_sum[47:0];
            pend.event_kind  <= EV_DONE;
            pend.last_of_run <= 1'b0;
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              if (req.req_type == REQ_DRAIN) begin
                state <= S_FIN;
              end else begin
                state <= S_INS;
              end
            end else begin
              state <= S_POP_RD;
            end
          end else begin
            ctime <= eff;
            state <= S_INS;
          end
        end
        S_POP_RD: begin
          state <= S_POP_LD;
        end
        S_POP_LD: begin
          elem  <= rdata;
          pos   <= '0;
          state <= S_DN_CHK;
        end
        S_DN_CHK: begin
          state <= (lidx < LW'(count)) ? S_DN_RDR : S_RD_ROOT;
        end
        S_DN_RDR: begin
          cand  <= rdata;
          cidx  <= lidx[AW-1:0];
          state <= (ridx < LW'(count)) ? S_DN_CMPR : S_DN_CMP;
        end
        S_DN_CMPR: begin
          if (ranks_above(rdata, cand)) begin
            cand <= rdata;
            cidx <= ridx[AW-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (ranks_above(cand, elem)) begin
            pos   <= cidx;
            state <= S_DN_CHK;
          end else begin
            state <= S_RD_ROOT;
          end
        end
        S_INS: begin
          if (count == CW'(HEAP_DEPTH)) begin
            pend_v           <= 1'b1;
            pend.done_id     <= req.task_id;
            pend.finish_time <= ctime;
            pend.event_kind  <= EV_DROP;
            pend.last_of_run <= 1'b0;
            state <= S_FIN;
          end else begin
            elem.id        <= req.task_id;
            elem.arrival   <= req.arrive_time;
            elem.remaining <= req.work_amount;
            elem.prio      <= req.priority_level;
            pos   <= count[AW-1:0];
            count <= count + CW'(1);
            state <= S_UP_CHK;
          end
        end
        S_UP_CHK: begin
          state <= (pos == '0) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (ranks_above(elem, rdata)) begin
            pos   <= up;
            state <= S_UP_CHK;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          pend_v <= 1'b0;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/preemptive_priority_task_scheduler_tb.sv */
// Testbench for the preemptive priority task scheduler: random and directed requests.
`timescale 1ns / 100ps

module preemptive_priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int DEPTH = 64;

  class completion_board;
    res_t   pending[$];
    entry_t heap[DEPTH];
    int     count;
    logic [47:0] clock_now;
    int     errors;
    int     checked;

    function new();
      count = 0;
      clock_now = '0;
      errors = 0;
      checked = 0;
    endfunction

    function bit above(int a, int b);
      if (heap[a].prio != heap[b].prio) return heap[a].prio > heap[b].prio;
      return heap[a].arrival < heap[b].arrival;
    endfunction

    function void swap_slots(int a, int b);
      entry_t t;
      t = heap[a];
      heap[a] = heap[b];
      heap[b] = t;
    endfunction

    function void push_task(entry_t e);
      int p;
      int u;
      p = count;
      heap[p] = e;
      count++;
      while (p > 0) begin
        u = (p - 1) / 2;
        if (!above(p, u)) break;
        swap_slots(p, u);
        p = u;
      end
    endfunction

    function void pop_top();
      int p;
      int pick;
      p = 0;
      count--;
      swap_slots(0, count);
      while (p * 2 + 1 < count) begin
        pick = p * 2 + 1;
        if (pick + 1 < count && above(pick + 1, pick)) pick = pick + 1;
        if (!above(pick, p)) break;
        swap_slots(p, pick);
        p = pick;
      end
    endfunction

    function void finish_top(ref res_t outs[$]);
      res_t r;
      clock_now = clock_now + 48'(heap[0].remaining);
      r.done_id = heap[0].id;
      r.finish_time = clock_now;
      r.event_kind = EV_DONE;
      r.last_of_run = 1'b0;
      outs.push_back(r);
      pop_top();
    endfunction

    function void note_request(req_t q);
      res_t   outs[$];
      entry_t e;
      logic [47:0] eff;
      if (q.req_type == REQ_DRAIN) begin
        while (count > 0) finish_top(outs);
      end else begin
        if (count == 0) begin
          clock_now = {16'h0, q.arrive_time};
        end else begin
          eff = ({16'h0, q.arrive_time} > clock_now) ? {16'h0, q.arrive_time} : clock_now;
          while (count > 0 &&
                 ({1'b0, clock_now} + 49'(heap[0].remaining)) <= {1'b0, eff})
            finish_top(outs);
          if (count > 0) begin
            heap[0].remaining = heap[0].remaining - 32'(eff - clock_now);
          end
          clock_now = eff;
        end
        if (count < DEPTH) begin
          e.id = q.task_id;
          e.arrival = q.arrive_time;
          e.remaining = q.work_amount;
          e.prio = q.priority_level;
          push_task(e);
        end else begin
          res_t r;
          r.done_id = q.task_id;
          r.finish_time = clock_now;
          r.event_kind = EV_DROP;
          r.last_of_run = 1'b0;
          outs.push_back(r);
        end
      end
      if (outs.size() > 0) outs[outs.size() - 1].last_of_run = 1'b1;
      foreach (outs[k]) pending.push_back(outs[k]);
    endfunction

    function void check_result(res_t got);
      res_t want;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.done_id !== want.done_id)
        report_mismatch($sformatf("done_id %0d, expected %0d", got.done_id, want.done_id));
      if (got.finish_time !== want.finish_time)
        report_mismatch($sformatf("finish_time %0d, expected %0d",
                                  got.finish_time, want.finish_time));
      if (got.event_kind !== want.event_kind)
        report_mismatch($sformatf("event_kind %0b, expected %0b",
                                  got.event_kind, want.event_kind));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                  got.last_of_run, want.last_of_run));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic result_valid;
  res_t result;

  completion_board board;
  int   idle_pct;
  int   sent;
  logic [31:0] arrive_now;

  preemptive_priority_task_scheduler #(.HEAP_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) board.check_result(result);
  end

  task automatic send_request(req_t q);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    request <= q;
    @(posedge clk);
    board.note_request(q);
    sent++;
    start <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_arrival(logic [15:0] id, logic [31:0] t, logic [31:0] w,
                              logic [15:0] p);
    req_t q;
    q.req_type = REQ_ARRIVAL;
    q.task_id = id;
    q.arrive_time = t;
    q.work_amount = w;
    q.priority_level = p;
    send_request(q);
  endtask

  task automatic send_drain();
    req_t q;
    q.req_type = REQ_DRAIN;
    q.task_id = 16'($urandom);
    q.arrive_time = $urandom;
    q.work_amount = $urandom;
    q.priority_level = 16'($urandom);
    send_request(q);
  endtask

  task automatic random_arrival(int step_max, int work_max);
    logic [31:0] w;
    logic [15:0] p;
    if ($urandom_range(9) == 0 && arrive_now > 5) arrive_now = arrive_now - 32'($urandom_range(5));
    else arrive_now = arrive_now + 32'($urandom_range(step_max));
    w = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(work_max));
    p = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
    send_arrival(16'($urandom), arrive_now, w, p);
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    idle_pct = 0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_drain();
    send_arrival(16'h0000, 32'd100, 32'd0, 16'h0000);
    send_arrival(16'hFFFF, 32'd100, 32'd50, 16'hFFFF);
    send_arrival(16'h1234, 32'd50, 32'd30, 16'hFFFF);
    send_arrival(16'h0042, 32'd120, 32'hFFFF_FFFF, 16'h0001);
    send_arrival(16'h0043, 32'd400, 32'd10, 16'h8000);
    send_drain();
    send_arrival(16'hA5A5, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'h5A5A);
    send_arrival(16'h5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5A5A);
    send_arrival(16'h0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5A5A);
    send_drain();
    for (int k = 0; k < DEPTH + 3; k++)
      send_arrival(16'(k), 32'd7, 32'd1000 + 32'(k), 16'($urandom_range(7)));
    send_drain();

    arrive_now = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 56 : (ph == 2) ? 0 : 13;
      for (int k = 0; k < 95; k++) begin
        if ($urandom_range(29) == 0) send_drain();
        else if (ph == 2) random_arrival(3, 400);
        else random_arrival(200, 300);
      end
      send_drain();
    end

    while (board.pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, %0d mismatches.",
             sent, board.checked, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
